// File: rtl/core/beld_pkg.sv
// Shared types, constants and register codes for the band energy load mode detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package beld_pkg;

  // Parameter defaults
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF    = 16;
  localparam int unsigned COUNT_WIDTH_DEF  = 10;

  // Fixed field widths
  localparam int unsigned GAIN_BITS  = 16;  // Q0.16 gains
  localparam int unsigned THR_W      = 32;  // energy thresholds, integer squared LSB
  localparam int unsigned TICK_W     = 10;  // tick count registers
  localparam int unsigned OUT_E_W    = 32;  // integer part of the energy
  localparam int unsigned SQ_W       = 32;  // largest band magnitude that is squared
  localparam int unsigned MUL_CNT_W  = 6;   // holds SQ_W serial steps
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [GAIN_BITS-1:0] HP_COEF_RST      = 16'd29789;
  localparam logic [GAIN_BITS-1:0] LP_COEF_RST      = 16'd38550;
  localparam logic [GAIN_BITS-1:0] EN_COEF_RST      = 16'd1074;
  localparam logic [THR_W-1:0]     LOADED_BELOW_RST = 32'd29653;
  localparam logic [THR_W-1:0]     EMPTY_ABOVE_RST  = 32'd226195;
  localparam logic [TICK_W-1:0]    PRIME_TICKS_RST  = 10'd180;
  localparam logic [TICK_W-1:0]    CONFIRM_TICKS_RST = 10'd400;
  localparam logic [TICK_W-1:0]    LOCKOUT_TICKS_RST = 10'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_COEF       = 3'd0,
    REG_LP_COEF       = 3'd1,
    REG_EN_COEF       = 3'd2,
    REG_LOADED_BELOW  = 3'd3,
    REG_EMPTY_ABOVE   = 3'd4,
    REG_PRIME_TICKS   = 3'd5,
    REG_CONFIRM_TICKS = 3'd6,
    REG_LOCKOUT_TICKS = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_PRIME   = 2'd0,
    PH_MOVING  = 2'd1,
    PH_LOCKOUT = 2'd2,
    PH_DECIDE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] hp_coef;
    logic [GAIN_BITS-1:0] lp_coef;
    logic [GAIN_BITS-1:0] en_coef;
    logic [THR_W-1:0]     loaded_below;
    logic [THR_W-1:0]     empty_above;
    logic [TICK_W-1:0]    prime_ticks;
    logic [TICK_W-1:0]    confirm_ticks;
    logic [TICK_W-1:0]    lockout_ticks;
  } cfg_t;

  // Request to the bit-serial multiplier
  typedef struct packed {
    logic                 start;
    logic [MUL_CNT_W-1:0] steps;
    logic                 rnd;    // preload half an LSB of the Q0.16 result
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef struct packed {
    logic idle;
    logic commit;   // result of the current sample is final this cycle
  } dp_stat_t;

endpackage

// File: rtl/core/beld_if.sv
// Valid/ready channel interfaces of the band energy load mode detector.
// Depends on beld_pkg for the default sample width and register index width.
`timescale 1ns / 1ps

interface beld_in_if import beld_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] gyro_sample;
  logic                           is_moving;

  modport source (output valid, output gyro_sample, output is_moving, input ready);
  modport sink   (input valid, input gyro_sample, input is_moving, output ready);
endinterface

interface beld_out_if import beld_pkg::*;;
  logic               valid;
  logic               ready;
  logic               heavy_mode;
  logic [OUT_E_W-1:0] band_energy;
  logic [1:0]         phase;

  modport source (output valid, output heavy_mode, output band_energy, output phase,
                  input ready);
  modport sink   (input valid, input heavy_mode, input band_energy, input phase,
                  output ready);
endinterface

interface beld_cfg_if import beld_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/beld_cfg_regs.sv
// Configuration register file: decodes write transactions into the gain,
// threshold and tick registers. Depends on beld_pkg and beld_cfg_if.
`timescale 1ns / 1ps

module beld_cfg_regs import beld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  beld_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_HP_COEF:       cfg_d.hp_coef       = cfg_i.data[GAIN_BITS-1:0];
        REG_LP_COEF:       cfg_d.lp_coef       = cfg_i.data[GAIN_BITS-1:0];
        REG_EN_COEF:       cfg_d.en_coef       = cfg_i.data[GAIN_BITS-1:0];
        REG_LOADED_BELOW:  cfg_d.loaded_below  = cfg_i.data[THR_W-1:0];
        REG_EMPTY_ABOVE:   cfg_d.empty_above   = cfg_i.data[THR_W-1:0];
        REG_PRIME_TICKS:   cfg_d.prime_ticks   = cfg_i.data[TICK_W-1:0];
        REG_CONFIRM_TICKS: cfg_d.confirm_ticks = cfg_i.data[TICK_W-1:0];
        REG_LOCKOUT_TICKS: cfg_d.lockout_ticks = cfg_i.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hp_coef       <= HP_COEF_RST;
      cfg_q.lp_coef       <= LP_COEF_RST;
      cfg_q.en_coef       <= EN_COEF_RST;
      cfg_q.loaded_below  <= LOADED_BELOW_RST;
      cfg_q.empty_above   <= EMPTY_ABOVE_RST;
      cfg_q.prime_ticks   <= PRIME_TICKS_RST;
      cfg_q.confirm_ticks <= CONFIRM_TICKS_RST;
      cfg_q.lockout_ticks <= LOCKOUT_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/beld_serial_mult.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first,
// with an optional rounding preload. Depends on beld_pkg.
`timescale 1ns / 1ps

module beld_serial_mult import beld_pkg::*; #(
  parameter int unsigned A_W = 48,
  parameter int unsigned P_W = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mul_req_t        req_i,
  input  logic [A_W-1:0]  a_i,
  input  logic [SQ_W-1:0] b_i,
  output mul_stat_t       stat_o,
  output logic [P_W-1:0]  prod_o
);

  localparam logic [P_W-1:0] ROUND_HALF = P_W'(1) << (GAIN_BITS - 1);

  logic                 run_q, run_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [P_W-1:0]       acc_q, acc_d;
  logic [P_W-1:0]       a_q, a_d;
  logic [SQ_W-1:0]      b_q, b_d;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = req_i.steps;
      acc_d = req_i.rnd ? ROUND_HALF : '0;
      a_d   = P_W'(a_i);
      b_d   = b_i;
    end else if (run_q) begin
      if (cnt_q != '0) begin
        acc_d = acc_q + (b_q[0] ? a_q : '0);
        a_d   = a_q << 1;
        b_d   = b_q >> 1;
        cnt_d = cnt_q - 1'b1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = run_q && (cnt_q == '0);
  assign prod_o      = acc_q;

endmodule

// File: rtl/core/beld_datapath.sv
// Filter datapath: running mean, band low-pass, squaring and energy smoothing,
// sequenced over the shared bit-serial multiplier. Depends on beld_pkg and
// beld_serial_mult.
`timescale 1ns / 1ps

module beld_datapath import beld_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [GAIN_BITS-1:0]           hp_coef_i,
  input  logic [GAIN_BITS-1:0]           lp_coef_i,
  input  logic [GAIN_BITS-1:0]           en_coef_i,
  input  logic                           out_free_i,
  output dp_stat_t                       stat_o,
  output logic [OUT_E_W+FRAC_BITS-1:0]   energy_o
);

  localparam int unsigned GQ_W   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int unsigned MEAN_W = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam int unsigned BAND_W = SAMPLE_WIDTH + FRAC_BITS + 3;
  localparam int unsigned E_W    = OUT_E_W + FRAC_BITS;
  localparam int unsigned A_W    = E_W;       // widest magnitude fed to the multiplier
  localparam int unsigned D_W    = A_W + 1;   // signed working width
  localparam int unsigned P_W    = (E_W + GAIN_BITS > 2 * SQ_W) ? E_W + GAIN_BITS : 2 * SQ_W;

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic signed [BAND_W-1:0] BAND_MAX = {1'b0, {(BAND_W-1){1'b1}}};
  localparam logic signed [BAND_W-1:0] BAND_MIN = {1'b1, {(BAND_W-1){1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_MEAN_LOAD = 12'b000000000010,
    S_MEAN_MUL  = 12'b000000000100,
    S_HP        = 12'b000000001000,
    S_BAND_LOAD = 12'b000000010000,
    S_BAND_MUL  = 12'b000000100000,
    S_BMAG      = 12'b000001000000,
    S_SQ_LOAD   = 12'b000010000000,
    S_SQ_MUL    = 12'b000100000000,
    S_EN_LOAD   = 12'b001000000000,
    S_EN_MUL    = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } dp_state_e;

  dp_state_e state_q, state_d;

  logic signed [GQ_W-1:0]   gq_q, gq_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic signed [BAND_W-1:0] hp_q, hp_d;
  logic signed [BAND_W-1:0] band_q, band_d;
  logic [A_W-1:0]           bmag_q, bmag_d;
  logic [E_W-1:0]           sq_q, sq_d;
  logic [E_W-1:0]           energy_q, energy_d;
  logic                     neg_q, neg_d;

  logic signed [D_W-1:0] tgt, cur, diff_pos, diff_neg, m_ext, upd, sat_src;
  logic [A_W-1:0]        mag;
  logic [D_W-MEAN_W:0]   mean_hi;
  logic [D_W-BAND_W:0]   band_hi;
  logic signed [MEAN_W-1:0] mean_sat;
  logic signed [BAND_W-1:0] band_sat;
  logic [E_W-1:0]        en_new, sq_new;
  logic [P_W-1:0]        sq_wide;
  logic                  sq_over, bmag_over, commit;

  mul_req_t        mul_req;
  mul_stat_t       mul_stat;
  logic [A_W-1:0]  mul_a;
  logic [SQ_W-1:0] mul_b;
  logic [P_W-1:0]  prod;

  beld_serial_mult #(
    .A_W (A_W),
    .P_W (P_W)
  ) u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (prod)
  );

  // Operand pair of the current filter step: tgt is what the state moves toward.
  always_comb begin
    tgt = '0;
    cur = '0;
    unique case (state_q) inside
      S_MEAN_LOAD, S_MEAN_MUL, S_HP: begin
        tgt = D_W'(gq_q);
        cur = D_W'(mean_q);
      end
      S_BAND_LOAD, S_BAND_MUL: begin
        tgt = D_W'(hp_q);
        cur = D_W'(band_q);
      end
      S_BMAG: begin
        tgt = D_W'(band_q);
      end
      S_EN_LOAD, S_EN_MUL: begin
        tgt = $signed({1'b0, sq_q});
        cur = $signed({1'b0, energy_q});
      end
      default: ;
    endcase
  end

  // Both differences in parallel so the magnitude costs one adder delay.
  assign diff_pos = tgt - cur;
  assign diff_neg = cur - tgt;
  assign mag      = diff_pos[D_W-1] ? diff_neg[A_W-1:0] : diff_pos[A_W-1:0];

  // Rounded step from the product, applied toward the target.
  assign m_ext = $signed({1'b0, prod[GAIN_BITS +: A_W]});
  assign upd   = neg_q ? cur - m_ext : cur + m_ext;

  assign mean_hi  = upd[D_W-1:MEAN_W-1];
  assign mean_sat = ((&mean_hi) || !(|mean_hi)) ? upd[MEAN_W-1:0]
                  : (upd[D_W-1] ? MEAN_MIN : MEAN_MAX);

  assign sat_src  = (state_q == S_HP) ? diff_pos : upd;
  assign band_hi  = sat_src[D_W-1:BAND_W-1];
  assign band_sat = ((&band_hi) || !(|band_hi)) ? sat_src[BAND_W-1:0]
                  : (sat_src[D_W-1] ? BAND_MIN : BAND_MAX);

  assign en_new = upd[D_W-1] ? '0 : upd[E_W-1:0];

  assign sq_wide   = prod >> FRAC_BITS;
  assign sq_over   = |sq_wide[P_W-1:E_W];
  assign sq_new    = sq_over ? '1 : sq_wide[E_W-1:0];
  assign bmag_over = |bmag_q[A_W-1:SQ_W];

  always_comb begin
    state_d  = state_q;
    gq_d     = gq_q;
    mean_d   = mean_q;
    hp_d     = hp_q;
    band_d   = band_q;
    bmag_d   = bmag_q;
    sq_d     = sq_q;
    energy_d = energy_q;
    neg_d    = neg_q;
    mul_req  = '0;
    mul_a    = mag;
    mul_b    = '0;
    commit   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          gq_d    = {sample_i, {FRAC_BITS{1'b0}}};
          state_d = S_MEAN_LOAD;
        end
      end
      S_MEAN_LOAD: begin
        neg_d         = diff_pos[D_W-1];
        mul_req.start = 1'b1;
        mul_req.steps = MUL_CNT_W'(GAIN_BITS);
        mul_req.rnd   = 1'b1;
        mul_b         = SQ_W'(hp_coef_i);
        state_d       = S_MEAN_MUL;
      end
      S_MEAN_MUL: begin
        if (mul_stat.done) begin
          mean_d  = mean_sat;
          state_d = S_HP;
        end
      end
      S_HP: begin
        hp_d    = band_sat;
        state_d = S_BAND_LOAD;
      end
      S_BAND_LOAD: begin
        neg_d         = diff_pos[D_W-1];
        mul_req.start = 1'b1;
        mul_req.steps = MUL_CNT_W'(GAIN_BITS);
        mul_req.rnd   = 1'b1;
        mul_b         = SQ_W'(lp_coef_i);
        state_d       = S_BAND_MUL;
      end
      S_BAND_MUL: begin
        if (mul_stat.done) begin
          band_d  = band_sat;
          state_d = S_BMAG;
        end
      end
      S_BMAG: begin
        bmag_d  = mag;
        state_d = S_SQ_LOAD;
      end
      S_SQ_LOAD: begin
        // A band magnitude beyond the square operand saturates the energy input.
        if (bmag_over) begin
          sq_d    = '1;
          state_d = S_EN_LOAD;
        end else begin
          mul_req.start = 1'b1;
          mul_req.steps = MUL_CNT_W'(SQ_W);
          mul_req.rnd   = 1'b0;
          mul_a         = bmag_q;
          mul_b         = bmag_q[SQ_W-1:0];
          state_d       = S_SQ_MUL;
        end
      end
      S_SQ_MUL: begin
        if (mul_stat.done) begin
          sq_d    = sq_new;
          state_d = S_EN_LOAD;
        end
      end
      S_EN_LOAD: begin
        neg_d         = diff_pos[D_W-1];
        mul_req.start = 1'b1;
        mul_req.steps = MUL_CNT_W'(GAIN_BITS);
        mul_req.rnd   = 1'b1;
        mul_b         = SQ_W'(en_coef_i);
        state_d       = S_EN_MUL;
      end
      S_EN_MUL: begin
        if (mul_stat.done) begin
          energy_d = en_new;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mean_q   <= '0;
      band_q   <= '0;
      energy_q <= '0;
    end else begin
      state_q  <= state_d;
      mean_q   <= mean_d;
      band_q   <= band_d;
      energy_q <= energy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gq_q   <= gq_d;
    hp_q   <= hp_d;
    bmag_q <= bmag_d;
    sq_q   <= sq_d;
    neg_q  <= neg_d;
  end

  assign stat_o.idle   = (state_q == S_IDLE);
  assign stat_o.commit = commit;
  assign energy_o      = energy_q;

`ifndef SYNTHESIS
  a_mul_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_stat.busy)
    else $error("multiplier restarted while still busy");

  a_commit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> out_free_i)
    else $error("result committed while the output register is occupied");

  a_start_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (state_q == S_IDLE) |=> mul_req.start)
    else $error("accepted sample did not start the mean multiply");
`endif

endmodule

// File: rtl/core/beld_mode_ctrl.sv
// Heavy/normal mode decision: priming, moving hold, lockout and confirmation
// counters against the energy thresholds. Depends on beld_pkg.
`timescale 1ns / 1ps

module beld_mode_ctrl import beld_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic                         moving_i,
  input  logic [OUT_E_W+FRAC_BITS-1:0] energy_i,
  input  cfg_t                         cfg_i,
  output logic                         heavy_o,
  output phase_e                       phase_o
);

  localparam int unsigned E_W   = OUT_E_W + FRAC_BITS;
  localparam int unsigned CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] prime_q, prime_d;
  logic [COUNT_WIDTH-1:0] confirm_q, confirm_d;
  logic [COUNT_WIDTH-1:0] lockout_q, lockout_d;
  logic [COUNT_WIDTH-1:0] confirm_inc;
  logic                   heavy_q, heavy_d, want;
  logic [E_W-1:0]         lo_thr, hi_thr;
  phase_e                 phase;

  assign lo_thr      = {cfg_i.loaded_below, {FRAC_BITS{1'b0}}};
  assign hi_thr      = {cfg_i.empty_above, {FRAC_BITS{1'b0}}};
  assign confirm_inc = (confirm_q != COUNT_MAX) ? confirm_q + 1'b1 : confirm_q;

  always_comb begin
    prime_d   = prime_q;
    confirm_d = confirm_q;
    lockout_d = lockout_q;
    heavy_d   = heavy_q;
    want      = heavy_q;
    phase     = PH_DECIDE;
    if (CMP_W'(prime_q) < CMP_W'(cfg_i.prime_ticks)) begin
      prime_d = prime_q + 1'b1;
      phase   = PH_PRIME;
    end else if (moving_i) begin
      confirm_d = '0;
      phase     = PH_MOVING;
    end else if (lockout_q != '0) begin
      lockout_d = lockout_q - 1'b1;
      confirm_d = '0;
      phase     = PH_LOCKOUT;
    end else begin
      if (!heavy_q && (energy_i < lo_thr)) begin
        want = 1'b1;
      end else if (heavy_q && (energy_i > hi_thr)) begin
        want = 1'b0;
      end
      if (want != heavy_q) begin
        // A confirm setting of zero acts as one: the first mismatch switches.
        if (CMP_W'(confirm_inc) >= CMP_W'(cfg_i.confirm_ticks)) begin
          heavy_d   = want;
          confirm_d = '0;
          lockout_d = COUNT_WIDTH'(cfg_i.lockout_ticks);
        end else begin
          confirm_d = confirm_inc;
        end
      end else begin
        confirm_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q   <= '0;
      confirm_q <= '0;
      lockout_q <= '0;
      heavy_q   <= 1'b1;
    end else if (upd_i) begin
      prime_q   <= prime_d;
      confirm_q <= confirm_d;
      lockout_q <= lockout_d;
      heavy_q   <= heavy_d;
    end
  end

  assign heavy_o = heavy_d;
  assign phase_o = phase;

`ifndef SYNTHESIS
  a_mode_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(heavy_q))
    else $error("mode changed without a sample update");

  a_switch_lockout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (heavy_d != heavy_q) |=>
      lockout_q == COUNT_WIDTH'($past(cfg_i.lockout_ticks)))
    else $error("mode switch did not load the lockout counter");

  a_confirm_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && ((phase == PH_MOVING) || (phase == PH_LOCKOUT)) |=> confirm_q == '0)
    else $error("confirmation count survived a moving or lockout tick");
`endif

endmodule

// File: rtl/core/band_energy_load_mode_detector_unit.sv
// Top level of the band energy load mode detector: channels, configuration
// registers, filter datapath, mode control and output register.
// Depends on beld_pkg, beld_if, beld_cfg_regs, beld_datapath and beld_mode_ctrl.
//
// Each accepted gyro sample is band-passed (sample minus a running mean, then a
// first-order low-pass), squared and smoothed into a band energy, and yields
// exactly one result: the heavy/normal mode after this sample, the integer part
// of the energy and the decision phase. All multiplies go through one bit-serial
// multiplier that retires one multiplier bit per cycle. Each sample passes the mean,
// band and energy Q0.16 gain multiplies and the square, with load and sequencing
// states between them; the square multiply is skipped and saturates when the band
// magnitude is too large for the square operand. A new sample is taken only while
// the datapath is idle, so one sample is in work at a time; a finished result waits
// in the output register while the next sample is taken, and that sample's result
// stalls until the register is free. The mode resets to heavy. Configuration writes
// take effect at once and belong between samples.
`timescale 1ns / 1ps

module band_energy_load_mode_detector_unit import beld_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  beld_in_if.sink     smp_i,
  beld_out_if.source  res_o,
  beld_cfg_if.sink    cfg_i
);

  localparam int unsigned E_W = OUT_E_W + FRAC_BITS;

  cfg_t           cfg;
  dp_stat_t       dp_stat;
  logic [E_W-1:0] dp_energy;
  logic           accept, out_free;
  logic           moving_q, moving_d;
  logic           mc_heavy;
  phase_e         mc_phase;

  logic               out_valid_q, out_valid_d;
  logic               heavy_q;
  logic [OUT_E_W-1:0] energy_q;
  logic [1:0]         phase_q;

  assign smp_i.ready = dp_stat.idle;
  assign accept      = smp_i.valid && smp_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign moving_d    = accept ? smp_i.is_moving : moving_q;

  beld_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  beld_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .sample_i   (smp_i.gyro_sample),
    .hp_coef_i  (cfg.hp_coef),
    .lp_coef_i  (cfg.lp_coef),
    .en_coef_i  (cfg.en_coef),
    .out_free_i (out_free),
    .stat_o     (dp_stat),
    .energy_o   (dp_energy)
  );

  beld_mode_ctrl #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (dp_stat.commit),
    .moving_i (moving_q),
    .energy_i (dp_energy),
    .cfg_i    (cfg),
    .heavy_o  (mc_heavy),
    .phase_o  (mc_phase)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_stat.commit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    moving_q <= moving_d;
    if (dp_stat.commit) begin
      heavy_q  <= mc_heavy;
      energy_q <= dp_energy[E_W-1:FRAC_BITS];
      phase_q  <= mc_phase;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.heavy_mode  = heavy_q;
  assign res_o.band_energy = energy_q;
  assign res_o.phase       = phase_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for band_energy_load_mode_detector_unit: an in-bench model of
// the filter chain and the mode control predicts every result and checks it field by field.
// Depends on beld_pkg, the beld_if channel interfaces and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import beld_pkg::*;

  localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int MEAN_W = SAMPLE_W + FRAC + 2;
  localparam int BAND_W = SAMPLE_W + FRAC + 3;
  localparam longint ENERGY_MAX = (longint'(1) <<< 48) - 1;
  localparam int unsigned CONFIRM_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  typedef struct {
    bit                 heavy;
    bit [OUT_E_W-1:0]   energy;
    phase_e             ph;
  } mode_result_t;

  logic clk;
  logic rst_n;

  beld_in_if  smp ();
  beld_out_if res ();
  beld_cfg_if cfg ();

  band_energy_load_mode_detector_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // Model state, a copy of the register file and the results still owed by the block.
  cfg_t setting_q = '{hp_coef: HP_COEF_RST, lp_coef: LP_COEF_RST, en_coef: EN_COEF_RST,
                      loaded_below: LOADED_BELOW_RST, empty_above: EMPTY_ABOVE_RST,
                      prime_ticks: PRIME_TICKS_RST, confirm_ticks: CONFIRM_TICKS_RST,
                      lockout_ticks: LOCKOUT_TICKS_RST};
  longint       mean_acc = 0;
  longint       band_acc = 0;
  longint       energy_acc = 0;
  int unsigned  confirm_cnt = 0;
  int unsigned  lockout_cnt = 0;
  int unsigned  prime_cnt = 0;
  bit           heavy_q = 1'b1;
  mode_result_t pending_modes[$];

  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat_signed(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One first-order filter step; the gain product is rounded half away from zero.
  function automatic longint smooth_step(input longint acc, input longint target,
                                         input bit [GAIN_BITS-1:0] gain);
    longint   diff;
    bit [63:0] mag;
    bit [63:0] delta;
    diff = target - acc;
    mag = (diff < 0) ? -diff : diff;
    delta = (mag * 64'(gain) + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
    return (diff < 0) ? acc - longint'(delta) : acc + longint'(delta);
  endfunction

  task automatic predict_mode(input logic signed [SAMPLE_W-1:0] g, input logic mv);
    longint       scaled;
    longint       hp;
    longint       e;
    bit [63:0]    bmag;
    bit [63:0]    sq;
    bit [63:0]    whole;
    bit           want;
    mode_result_t r;
    scaled = longint'(g) * (longint'(1) <<< FRAC);
    mean_acc = sat_signed(smooth_step(mean_acc, scaled, setting_q.hp_coef), MEAN_W);
    hp = sat_signed(scaled - mean_acc, BAND_W);
    band_acc = sat_signed(smooth_step(band_acc, hp, setting_q.lp_coef), BAND_W);
    bmag = (band_acc < 0) ? -band_acc : band_acc;
    if (bmag >= (64'd1 << SQ_W)) begin
      sq = ENERGY_MAX;
    end else begin
      sq = (bmag * bmag) >> FRAC;
      if (sq > ENERGY_MAX) sq = ENERGY_MAX;
    end
    e = smooth_step(energy_acc, longint'(sq), setting_q.en_coef);
    if (e < 0) e = 0;
    if (e > ENERGY_MAX) e = ENERGY_MAX;
    energy_acc = e;

    if (prime_cnt < setting_q.prime_ticks) begin
      prime_cnt++;
      r.ph = PH_PRIME;
    end else if (mv) begin
      confirm_cnt = 0;
      r.ph = PH_MOVING;
    end else if (lockout_cnt > 0) begin
      lockout_cnt--;
      confirm_cnt = 0;
      r.ph = PH_LOCKOUT;
    end else begin
      want = heavy_q;
      if (!heavy_q && energy_acc < (longint'(setting_q.loaded_below) <<< FRAC)) begin
        want = 1'b1;
      end else if (heavy_q && energy_acc > (longint'(setting_q.empty_above) <<< FRAC)) begin
        want = 1'b0;
      end
      if (want != heavy_q) begin
        if (confirm_cnt < CONFIRM_MAX) confirm_cnt++;
        // A confirm setting of zero switches on the first mismatch, like one.
        if (confirm_cnt >= setting_q.confirm_ticks) begin
          heavy_q = want;
          confirm_cnt = 0;
          lockout_cnt = setting_q.lockout_ticks;
        end
      end else begin
        confirm_cnt = 0;
      end
      r.ph = PH_DECIDE;
    end

    whole = 64'(energy_acc) >> FRAC;
    if (whole > 64'hFFFF_FFFF) whole = 64'hFFFF_FFFF;
    r.heavy = heavy_q;
    r.energy = whole[OUT_E_W-1:0];
    pending_modes.push_back(r);
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Tracks register writes and samples, and checks every result transaction in order.
  always @(posedge clk) begin : mode_tracking
    mode_result_t want;
    if (rst_n) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.index))
          REG_HP_COEF:       setting_q.hp_coef = cfg.data[GAIN_BITS-1:0];
          REG_LP_COEF:       setting_q.lp_coef = cfg.data[GAIN_BITS-1:0];
          REG_EN_COEF:       setting_q.en_coef = cfg.data[GAIN_BITS-1:0];
          REG_LOADED_BELOW:  setting_q.loaded_below = cfg.data[THR_W-1:0];
          REG_EMPTY_ABOVE:   setting_q.empty_above = cfg.data[THR_W-1:0];
          REG_PRIME_TICKS:   setting_q.prime_ticks = cfg.data[TICK_W-1:0];
          REG_CONFIRM_TICKS: setting_q.confirm_ticks = cfg.data[TICK_W-1:0];
          REG_LOCKOUT_TICKS: setting_q.lockout_ticks = cfg.data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) predict_mode(smp.gyro_sample, smp.is_moving);
      if (res.valid && res.ready) begin
        if (pending_modes.size() == 0) begin
          flag_mismatch("result transaction with no sample pending");
        end else begin
          want = pending_modes.pop_front();
          if (res.heavy_mode !== want.heavy)
            flag_mismatch($sformatf("heavy_mode %b, expected %b", res.heavy_mode, want.heavy));
          if (res.band_energy !== want.energy)
            flag_mismatch($sformatf("band_energy %0d, expected %0d",
                                    res.band_energy, want.energy));
          if (res.phase !== want.ph)
            flag_mismatch($sformatf("phase %0d, expected %s", res.phase, want.ph.name()));
        end
      end
    end
  end

  // Result ready: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = hold_cycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready = 1'b0;
    end else begin
      res.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] g, input logic mv);
    while ($urandom_range(99) < idle_pct) begin
      smp.valid = 1'b0;
      smp.gyro_sample = SAMPLE_W'($urandom);
      smp.is_moving = 1'($urandom);
      @(negedge clk);
    end
    smp.valid = 1'b1;
    smp.gyro_sample = g;
    smp.is_moving = mv;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    smp.valid = 1'b0;
    while (pending_modes.size() != 0) @(negedge clk);
  endtask

  task automatic load_setting(input cfg_t c);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg.valid = 1'b1;
      cfg.index = r;
      case (r)
        REG_HP_COEF:       cfg.data = CFG_DATA_W'(c.hp_coef);
        REG_LP_COEF:       cfg.data = CFG_DATA_W'(c.lp_coef);
        REG_EN_COEF:       cfg.data = CFG_DATA_W'(c.en_coef);
        REG_LOADED_BELOW:  cfg.data = CFG_DATA_W'(c.loaded_below);
        REG_EMPTY_ABOVE:   cfg.data = CFG_DATA_W'(c.empty_above);
        REG_PRIME_TICKS:   cfg.data = CFG_DATA_W'(c.prime_ticks);
        REG_CONFIRM_TICKS: cfg.data = CFG_DATA_W'(c.confirm_ticks);
        REG_LOCKOUT_TICKS: cfg.data = CFG_DATA_W'(c.lockout_ticks);
        default:           cfg.data = '0;
      endcase
      do @(posedge clk); while (!cfg.ready);
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg.valid = 1'b0;
  endtask

  // Settings fast enough that both mode switches happen within a few hundred ticks.
  function automatic cfg_t random_setting();
    cfg_t c;
    c.hp_coef = GAIN_BITS'($urandom_range(45000, 4000));
    c.lp_coef = GAIN_BITS'($urandom_range(65535, 8000));
    c.en_coef = GAIN_BITS'($urandom_range(40000, 6000));
    c.loaded_below = $urandom_range(20000, 200);
    c.empty_above = $urandom_range(2000000, 50000);
    c.prime_ticks = TICK_W'($urandom_range(40));
    c.confirm_ticks = TICK_W'($urandom_range(25));
    c.lockout_ticks = TICK_W'($urandom_range(40));
    return c;
  endfunction

  // Quiet and loud stretches drive the energy across both thresholds; some stretches
  // are driven while moving, some are raw full-range noise.
  task automatic drive_segments(input int n);
    int sent;
    int len;
    int kind;
    int amp;
    bit mv;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(120, 10);
      kind = $urandom_range(99);
      mv = ($urandom_range(99) < 10);
      if (kind < 40) amp = $urandom_range(8);
      else if (kind < 85) amp = (1 << $urandom_range(15, 9)) - 1;
      else amp = -1;
      for (int k = 0; k < len && sent < n; k++) begin
        if (amp < 0) send_sample(SAMPLE_W'($urandom), 1'($urandom));
        else send_sample(SAMPLE_W'($urandom_range(2 * amp) - amp),
                         mv ^ ($urandom_range(99) < 3));
        sent++;
      end
    end
  endtask

  // Field extremes while still priming under the reset register values.
  task automatic test_reset_values();
    send_sample(0, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    send_sample(0, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b1);
    drain();
  endtask

  task automatic test_extreme_settings();
    cfg_t c;
    // Full gains and full-scale swings exercise the filters; with zero confirm and
    // lockout the mode flips on every mismatch.
    c = '{hp_coef: '1, lp_coef: '1, en_coef: '1, loaded_below: '1, empty_above: '1,
          prime_ticks: '0, confirm_ticks: '0, lockout_ticks: '0};
    load_setting(c);
    repeat (4) begin
      send_sample(32767, 1'b0);
      send_sample(-32768, 1'b0);
    end
    drain();
    // Zero gains freeze the filters; the longest warm-up puts the detector back in priming.
    c = '{hp_coef: '0, lp_coef: '0, en_coef: '0, loaded_below: '0, empty_above: '0,
          prime_ticks: '1, confirm_ticks: '1, lockout_ticks: '1};
    load_setting(c);
    send_sample(32767, 1'b1);
    send_sample(-32768, 1'b0);
    send_sample(0, 1'b1);
    send_sample(-1, 1'b0);
    drain();
  endtask

  task automatic test_output_backpressure();
    load_setting(random_setting());
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    hold_req++;
    repeat (24) send_sample(SAMPLE_W'($urandom), 1'($urandom));
    drain();
  endtask

  task automatic test_random_traffic();
    int   idle_mix[4];
    int   stall_mix[4];
    cfg_t c;
    idle_mix = '{0, 63, 0, 25};
    stall_mix = '{0, 0, 63, 25};
    for (int p = 0; p < 8; p++) begin
      c = random_setting();
      if (p == 7) begin
        c.confirm_ticks = 1;
        c.lockout_ticks = '1;
      end
      load_setting(c);
      idle_pct = idle_mix[p % 4];
      stall_pct = stall_mix[p % 4];
      drive_segments(205);
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    smp.valid = 1'b0;
    smp.gyro_sample = '0;
    smp.is_moving = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_HP_COEF;
    cfg.data = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_extreme_settings();
    test_output_backpressure();
    test_random_traffic();

    // Leave room for any stray result transaction to show up.
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
